// File: src/cndt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cndt_pkg
// Shared types, sizes, status codes and the case-folding helper for the
// caseless name de-duplication table.
// ----------------------------------------------------------------------------
package cndt_pkg;

    // table geometry
    localparam int NAME_SLOTS  = 32;
    localparam int NAME_CHARS  = 16;
    localparam int QUEUE_DEPTH = 2;

    // derived widths
    localparam int CHR_W      = 8;
    localparam int SLOT_W     = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NAME_SLOTS + 1);
    localparam int LEN_W      = $clog2(NAME_CHARS + 1);
    localparam int CIDX_W     = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_OUT_W = 5;
    localparam int HELD_W     = 6;

    typedef logic [CHR_W-1:0] char_t;

    // case folding bounds, a..z only
    localparam char_t LOWER_FIRST = 8'd97;
    localparam char_t LOWER_LAST  = 8'd122;
    localparam char_t CASE_OFFSET = 8'd32;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    typedef struct packed {
        char_t char_code;
        logic  last_char;
    } in_item_t;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_OUT_W-1:0]   slot_index;
        logic [HELD_W-1:0]       names_held;
    } out_item_t;

    // one complete name handed from front to back
    typedef struct packed {
        logic [NAME_CHARS-1:0][CHR_W-1:0] chars;
        logic [LEN_W-1:0]                 len;
        logic                             too_long;
    } name_job_t;

    // one table row: stored length and bytes in original case
    typedef struct packed {
        logic [LEN_W-1:0]                 len;
        logic [NAME_CHARS-1:0][CHR_W-1:0] chars;
    } name_row_t;

    function automatic char_t fold_upper(char_t c);
        char_t r;
        r = c;
        if (c >= LOWER_FIRST && c <= LOWER_LAST)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: src/cndt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cndt_front
// Collects name bytes into a pending buffer, flags overlong names and hands
// each finished name to the job queue.
// ----------------------------------------------------------------------------
module cndt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 q_full,
    input  cndt_pkg::in_item_t   item,
    output logic                 push,
    output cndt_pkg::name_job_t  job
);
    import cndt_pkg::*;

    logic [NAME_CHARS-1:0][CHR_W-1:0] pend_reg, pend_next;
    logic [LEN_W-1:0]                 len_reg, len_next, len_fill;
    logic                             over_reg, over_next, over_fill;
    logic                             accept;

    assign accept = start && !q_full;

    // byte capture and end-of-name hand-off
    always_comb
    begin
        pend_next = pend_reg;
        len_fill  = len_reg;
        over_fill = over_reg;
        if (accept)
        begin
            if (len_reg < LEN_W'(NAME_CHARS))
            begin
                pend_next[len_reg[CIDX_W-1:0]] = item.char_code;
                len_fill = len_reg + LEN_W'(1);
            end
            else
            begin
                over_fill = 1'b1;
            end
        end
        push         = accept && item.last_char;
        job.chars    = pend_next;
        job.len      = len_fill;
        job.too_long = over_fill;
        len_next     = push ? '0 : len_fill;
        over_next    = push ? 1'b0 : over_fill;
    end

    // pending byte buffer
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // pending length and overlong flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            over_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            over_reg <= over_next;
        end
    end

endmodule

// File: src/cndt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cndt_queue
// Short first-in first-out queue of finished names between the front and
// the table search.
// ----------------------------------------------------------------------------
module cndt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cndt_pkg::name_job_t  job_in,
    input  logic                 pop,
    output cndt_pkg::name_job_t  job_out,
    output logic                 full,
    output logic                 empty
);
    import cndt_pkg::*;

    name_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign job_out = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // no overflow, no underflow, count moves only on a lone push or pop
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ($past(push) != $past(pop)))
        else $error("queue count changed without a lone push or pop");

endmodule

// File: src/cndt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cndt_back
// Takes finished names from the queue, walks the filled table rows one per
// cycle for a caseless match, then stores new names and reports each beat.
// ----------------------------------------------------------------------------
module cndt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  cndt_pkg::name_job_t  job,
    output logic                 pop,
    output logic                 done,
    output cndt_pkg::out_item_t  result
);
    import cndt_pkg::*;

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t             state_reg, state_next;
    name_job_t          job_reg, job_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]  cmp_slot_reg, cmp_slot_next;
    logic               done_reg, done_next;
    out_item_t          res_reg, res_next;

    name_row_t          name_mem [NAME_SLOTS];
    name_row_t          rd_row_reg;
    name_row_t          wr_row;
    logic               rd_en, wr_en;
    logic [SLOT_W-1:0]  rd_addr, wr_addr;
    logic               hit;

    // caseless compare of one stored row against the current name
    function automatic logic row_match(name_row_t r, name_job_t j);
        logic eq;
        eq = (r.len == j.len);
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            if (LEN_W'(i) < j.len && fold_upper(r.chars[i]) != fold_upper(j.chars[i]))
            begin
                eq = 1'b0;
            end
        end
        return eq;
    endfunction

    assign hit    = cmp_valid_reg && row_match(rd_row_reg, job_reg);
    assign wr_row = '{len: job_reg.len, chars: job_reg.chars};

    // search sequencer
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_slot_next  = cmp_slot_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[SLOT_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[SLOT_W-1:0];
        unique case (state_reg)
            IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    job_next = job;
                    if (job.too_long)
                    begin
                        done_next           = 1'b1;
                        res_next.status     = ST_TOO_LONG;
                        res_next.slot_index = '0;
                        res_next.names_held = HELD_W'(cnt_reg);
                    end
                    else
                    begin
                        state_next = SCAN;
                        issue_next = '0;
                    end
                end
            end
            SCAN:
            begin
                if (hit)
                begin
                    // first matching row wins
                    done_next           = 1'b1;
                    res_next.status     = ST_DUPLICATE;
                    res_next.slot_index = SLOT_OUT_W'(cmp_slot_reg);
                    res_next.names_held = HELD_W'(cnt_reg);
                    state_next          = IDLE;
                end
                else if (!cmp_valid_reg && issue_reg >= cnt_reg)
                begin
                    // all filled rows checked, no match
                    done_next  = 1'b1;
                    state_next = IDLE;
                    if (cnt_reg == CNT_W'(NAME_SLOTS))
                    begin
                        res_next.status     = ST_FULL;
                        res_next.slot_index = '0;
                        res_next.names_held = HELD_W'(cnt_reg);
                    end
                    else
                    begin
                        wr_en               = 1'b1;
                        cnt_next            = cnt_reg + CNT_W'(1);
                        res_next.status     = ST_STORED;
                        res_next.slot_index = SLOT_OUT_W'(cnt_reg);
                        res_next.names_held = HELD_W'(cnt_next);
                    end
                end
                else if (issue_reg < cnt_reg)
                begin
                    // read the next filled row
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = issue_reg[SLOT_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // name table, one row per slot, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            name_mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= name_mem[rd_addr];
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            job_reg       <= '0;
            cnt_reg       <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_slot_reg  <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_slot_reg  <= cmp_slot_next;
            done_reg      <= done_next;
            res_reg       <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    // entry count moves only together with a stored beat
    a_count_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> (done_reg && res_reg.status == ST_STORED))
        else $error("entry count changed without a stored result");

    // only filled rows are ever compared
    a_cmp_filled_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (CNT_W'(cmp_slot_reg) < cnt_reg))
        else $error("compared a row that was never filled");

endmodule

// File: src/caseless_name_dedup_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caseless_name_dedup_table
// Caseless name de-duplication table: names come in one byte per beat and
// each finished name is checked against the table and stored if new.
// ----------------------------------------------------------------------------
// A byte is taken on each cycle with start high and busy low; last_char marks
// the final byte of a name. A finished name goes into a two-entry queue, so
// busy rises only while two names wait for the search. The search reads one
// table row per cycle from the row memory: a name produces its result beat on
// done after walking the filled rows up to a match (up to 32), and an overlong
// name reports without a table search. done is high for one cycle per beat
// and cannot be held off; results come out in name order.
// ----------------------------------------------------------------------------
module caseless_name_dedup_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cndt_pkg::in_item_t   item,
    output logic                 done,
    output cndt_pkg::out_item_t  result
);
    import cndt_pkg::*;

    name_job_t  push_job;
    name_job_t  head_job;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    assign busy = q_full;

    // byte collection
    cndt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .q_full (q_full),
        .item   (item),
        .push   (push),
        .job    (push_job)
    );

    // finished names waiting for the search
    cndt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (push_job),
        .pop     (pop),
        .job_out (head_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    // table search and store
    cndt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (q_empty),
        .job    (head_job),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the caseless name de-duplication table. Names go in
// one byte per beat under start/busy. A scoreboard keeps its own copy of the
// name table, works out the status, slot and count due at each end of name,
// and checks every done beat against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb;
    import cndt_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int POOL_SIZE     = 64;
    localparam int BUF_MAX       = 24;

    // bytes around the case-folding boundaries and the top bit
    localparam char_t RIM_CHARS [14] = '{8'h00, 8'h40, 8'h41, 8'h5a, 8'h5b, 8'h60,
                                         8'h61, 8'h7a, 8'h7b, 8'h7f, 8'h80, 8'hc1,
                                         8'he1, 8'hff};

    // scoreboard: shadow name table and queue of expected result beats
    class dedup_tracker;
        char_t     row_chars [NAME_SLOTS][NAME_CHARS];
        int        row_len [NAME_SLOTS];
        int        held;
        char_t     pend_chars [NAME_CHARS];
        int        pend_len;
        bit        overlong;
        out_item_t expected_beats [$];
        int        errors;
        int        bytes_seen;
        int        status_hits [4];

        function new();
            held       = 0;
            pend_len   = 0;
            overlong   = 1'b0;
            errors     = 0;
            bytes_seen = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function char_t upcase(char_t c);
            if (c >= LOWER_FIRST && c <= LOWER_LAST)
                return c - CASE_OFFSET;
            return c;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("tb: mismatch at %0t: %s", $time, what);
        endtask

        // one accepted input beat; an end of name queues one expectation
        task note_byte(in_item_t beat);
            out_item_t r;
            int        hit;
            bit        same;
            bytes_seen++;
            if (pend_len < NAME_CHARS)
            begin
                pend_chars[pend_len] = beat.char_code;
                pend_len++;
            end
            else
            begin
                overlong = 1'b1;
            end
            if (!beat.last_char)
                return;

            r = '0;
            if (overlong)
            begin
                r.status = ST_TOO_LONG;
            end
            else
            begin
                // first filled row of equal length that matches caselessly
                hit = -1;
                for (int s = 0; s < held && hit < 0; s++)
                begin
                    same = (row_len[s] == pend_len);
                    for (int i = 0; i < pend_len && same; i++)
                        if (upcase(row_chars[s][i]) != upcase(pend_chars[i]))
                            same = 1'b0;
                    if (same)
                        hit = s;
                end
                if (hit >= 0)
                begin
                    r.status     = ST_DUPLICATE;
                    r.slot_index = SLOT_OUT_W'(hit);
                end
                else if (held >= NAME_SLOTS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < pend_len; i++)
                        row_chars[held][i] = pend_chars[i];
                    row_len[held] = pend_len;
                    r.status      = ST_STORED;
                    r.slot_index  = SLOT_OUT_W'(held);
                    held++;
                end
            end
            r.names_held = HELD_W'(held);
            status_hits[r.status]++;
            expected_beats.push_back(r);
            pend_len = 0;
            overlong = 1'b0;
        endtask

        // one result beat from done
        task check_beat(out_item_t got);
            out_item_t want;
            if (expected_beats.size() == 0)
            begin
                report($sformatf("result beat with nothing expected (status %0d)",
                                 got.status));
                return;
            end
            want = expected_beats.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.slot_index !== want.slot_index)
                report($sformatf("slot_index %0d, expected %0d",
                                 got.slot_index, want.slot_index));
            if (got.names_held !== want.names_held)
                report($sformatf("names_held %0d, expected %0d",
                                 got.names_held, want.names_held));
        endtask

        task check_drained();
            if (expected_beats.size() != 0)
                report($sformatf("%0d results never arrived", expected_beats.size()));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    logic         busy;
    in_item_t     item;
    logic         done;
    out_item_t    result;

    dedup_tracker tracker;
    int           idle_pct;
    char_t        name_buf [BUF_MAX];
    int           name_len;
    char_t        pool_chars [POOL_SIZE][NAME_CHARS];
    int           pool_len [POOL_SIZE];
    int           pool_count;

    caseless_name_dedup_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watch both sides at the clock edge
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            tracker.note_byte(item);
        if (rst_n && done)
            tracker.check_beat(result);
    end

    function automatic bit is_letter(char_t c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= LOWER_FIRST && c <= LOWER_LAST);
    endfunction

    function automatic void add_char(char_t c);
        if (name_len < BUF_MAX)
        begin
            name_buf[name_len] = c;
            name_len++;
        end
    endfunction

    // offer one byte, wait for the beat to be taken, maybe idle afterwards
    task automatic send_byte(char_t c, logic last);
        int gap;
        start <= 1'b1;
        item  <= '{char_code: c, last_char: last};
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // send the name in name_buf and keep short ones for later reuse
    task automatic send_name();
        int dst;
        for (int i = 0; i < name_len; i++)
            send_byte(name_buf[i], i == name_len - 1);
        if (name_len <= NAME_CHARS)
        begin
            if (pool_count < POOL_SIZE)
            begin
                dst = pool_count;
                pool_count++;
            end
            else
            begin
                dst = $urandom_range(POOL_SIZE - 1);
            end
            pool_len[dst] = name_len;
            for (int i = 0; i < name_len; i++)
                pool_chars[dst][i] = name_buf[i];
        end
    endtask

    // stop sending until every expected result is back, then let the block settle
    task automatic hold_until_drained();
        int waited;
        start <= 1'b0;
        // let the monitor log the beat taken at this edge first
        @(negedge clk);
        waited = 0;
        while (tracker.expected_beats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random names: case variants of earlier names, near misses, overlong, fresh
    task automatic run_phase(int byte_target, int pct);
        int    kind;
        int    src;
        int    pos;
        int    len;
        int    stop_at;
        char_t c;
        idle_pct = pct;
        stop_at  = tracker.bytes_seen + byte_target;
        while (tracker.bytes_seen < stop_at)
        begin
            kind     = $urandom_range(99);
            name_len = 0;
            if (pool_count > 0 && kind < 30)
            begin
                // same name with letters in random case
                src = $urandom_range(pool_count - 1);
                for (int i = 0; i < pool_len[src]; i++)
                begin
                    c = pool_chars[src][i];
                    if (is_letter(c) && $urandom_range(1))
                        c = c ^ 8'h20;
                    add_char(c);
                end
            end
            else if (pool_count > 0 && kind < 42)
            begin
                // near miss: one byte altered, or one byte more or less
                src = $urandom_range(pool_count - 1);
                for (int i = 0; i < pool_len[src]; i++)
                    add_char(pool_chars[src][i]);
                pos = $urandom_range(name_len - 1);
                case ($urandom_range(2))
                    0:
                    begin
                        if (is_letter(name_buf[pos]) || $urandom_range(1))
                            name_buf[pos] = name_buf[pos] ^ 8'h80;
                        else
                            name_buf[pos] = name_buf[pos] ^ 8'h20;
                    end
                    1:
                    begin
                        if (name_len > 1)
                            name_len--;
                        else
                            add_char(8'($urandom_range(255)));
                    end
                    default:
                    begin
                        if (name_len < NAME_CHARS)
                            add_char(8'($urandom_range(255)));
                        else
                            name_buf[pos] = name_buf[pos] ^ 8'h80;
                    end
                endcase
            end
            else if (kind < 52)
            begin
                // overlong name, dropped by the block
                len = $urandom_range(NAME_CHARS + 1, NAME_CHARS + 6);
                repeat (len) add_char(8'($urandom_range(255)));
            end
            else
            begin
                // fresh name, mostly short
                len = ($urandom_range(3) == 0) ? $urandom_range(1, NAME_CHARS)
                                               : $urandom_range(1, 5);
                repeat (len)
                begin
                    case ($urandom_range(3))
                        0:       c = 8'($urandom_range(65, 90));
                        1:       c = 8'($urandom_range(97, 122));
                        2:       c = RIM_CHARS[$urandom_range(13)];
                        default: c = 8'($urandom_range(255));
                    endcase
                    add_char(c);
                end
            end
            send_name();
            if ($urandom_range(49) == 0)
                hold_until_drained();
        end
    endtask

    // main sequence
    initial
    begin
        tracker    = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        idle_pct   = 13;
        pool_count = 0;
        name_len   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fold a..z only, zero and all-ones bytes, overlong name
        name_len = 0;
        add_char(8'h61);
        send_name();
        name_len = 0;
        add_char(8'h41);
        send_name();
        name_len = 0;
        add_char(8'h00);
        add_char(8'hff);
        send_name();
        name_len = 0;
        add_char(8'h5b);
        send_name();
        name_len = 0;
        add_char(8'h7b);
        send_name();
        name_len = 0;
        for (int i = 0; i <= NAME_CHARS; i++)
            add_char(8'h41 + 8'(i));
        send_name();
        hold_until_drained();

        run_phase(370, 13);
        hold_until_drained();
        run_phase(370, 56);
        hold_until_drained();
        run_phase(370, 0);
        hold_until_drained();
        tracker.check_drained();

        $display("tb: %0d bytes sent; names stored %0d, duplicate %0d, full %0d, too long %0d",
                 tracker.bytes_seen, tracker.status_hits[ST_STORED],
                 tracker.status_hits[ST_DUPLICATE], tracker.status_hits[ST_FULL],
                 tracker.status_hits[ST_TOO_LONG]);
        $display("tb: table ended with %0d of %0d slots filled", tracker.held, NAME_SLOTS);
        if (tracker.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule
